@@ rtl/gr48_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gr48_pkg
// Shared types and constants of the 4x8 glyph rasterizer.
// ----------------------------------------------------------------------------
package gr48_pkg;

  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 200;
  localparam int BOTTOM_LIMIT  = (SCREEN_HEIGHT > 256) ? 256 : SCREEN_HEIGHT;
  localparam int FONT_DEPTH    = 384;
  localparam int GLYPH_W       = 4;
  localparam int GLYPH_H       = 8;
  localparam int GLYPH_BITS    = GLYPH_W * GLYPH_H;
  localparam int COL_LIMIT     = 511;

  localparam logic [7:0] CODE_FIRST     = 8'h20;
  localparam logic [7:0] CODE_LAST      = 8'h7F;
  localparam logic [7:0] TEXT_COLOR_RST = 8'd15;
  localparam logic [3:0] LINE_STEP_RST  = 4'd8;

  typedef enum logic [1:0] {
    CMD_DRAW       = 2'd0,
    CMD_LOAD       = 2'd1,
    CMD_SET_CURSOR = 2'd2
  } cmd_e;

  typedef enum logic {
    REG_TEXT_COLOR = 1'b0,
    REG_LINE_STEP  = 1'b1
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic start_draw;
    logic load_font;
    logic set_cursor;
    logic fetch;
    logic emit;
    logic shift;
    logic advance;
  } dp_cmd_t;

  typedef struct packed {
    logic is_draw;
    logic is_load;
    logic is_set;
    logic fetch_done;
    logic glyph_empty;
    logic bit_set;
    logic out_free;
  } dp_stat_t;

endpackage

@@ rtl/gr48_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gr48_in_if
// Command word channel: draw, font load and cursor set.
// ----------------------------------------------------------------------------
interface gr48_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] char_code;
  logic [8:0] font_addr;
  logic [7:0] font_byte;
  logic [8:0] new_cursor_x;
  logic [7:0] new_cursor_y;

  modport source (
    output valid, cmd, char_code, font_addr, font_byte, new_cursor_x, new_cursor_y,
    input  ready
  );
  modport sink (
    input  valid, cmd, char_code, font_addr, font_byte, new_cursor_x, new_cursor_y,
    output ready
  );
endinterface

@@ rtl/gr48_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gr48_out_if
// Pixel write word channel.
// ----------------------------------------------------------------------------
interface gr48_out_if;
  logic       valid;
  logic       ready;
  logic [8:0] pixel_x;
  logic [7:0] pixel_y;
  logic [7:0] pixel_color;
  logic       last;

  modport source (
    output valid, pixel_x, pixel_y, pixel_color, last,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, pixel_color, last,
    output ready
  );
endinterface

@@ rtl/gr48_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gr48_regs
// APB register file: text color and line step.
// ----------------------------------------------------------------------------
module gr48_regs (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  text_color_o,
  output logic [3:0]  line_step_o
);

  logic [7:0] text_color_q;
  logic [3:0] line_step_q;
  logic       wr_en;
  gr48_pkg::reg_e sel;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign sel    = gr48_pkg::reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_color_q <= gr48_pkg::TEXT_COLOR_RST;
      line_step_q  <= gr48_pkg::LINE_STEP_RST;
    end else if (wr_en) begin
      unique case (sel)
        gr48_pkg::REG_TEXT_COLOR: text_color_q <= pwdata[7:0];
        gr48_pkg::REG_LINE_STEP:  line_step_q  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      gr48_pkg::REG_TEXT_COLOR: prdata = {24'd0, text_color_q};
      gr48_pkg::REG_LINE_STEP:  prdata = {28'd0, line_step_q};
      default:                  prdata = 32'd0;
    endcase
  end

  assign text_color_o = text_color_q;
  assign line_step_o  = line_step_q;

endmodule

@@ rtl/gr48_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gr48_ctrl
// Sequencer: accept a command word, fetch glyph rows, step through pixels.
// ----------------------------------------------------------------------------
module gr48_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  gr48_pkg::dp_stat_t stat_i,
  output gr48_pkg::dp_cmd_t  cmd_o
);

  gr48_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gr48_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      gr48_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_font  = stat_i.is_load;
          cmd_o.set_cursor = stat_i.is_set;
          if (stat_i.is_draw) begin
            cmd_o.start_draw = 1'b1;
            state_d          = gr48_pkg::ST_FETCH;
          end
        end
      end
      gr48_pkg::ST_FETCH: begin
        cmd_o.fetch = 1'b1;
        if (stat_i.fetch_done) begin
          state_d = gr48_pkg::ST_DRAIN;
        end
      end
      gr48_pkg::ST_DRAIN: begin
        state_d = gr48_pkg::ST_EMIT;
      end
      gr48_pkg::ST_EMIT: begin
        if (stat_i.glyph_empty) begin
          cmd_o.advance = 1'b1;
          state_d       = gr48_pkg::ST_IDLE;
        end else if (!stat_i.bit_set) begin
          cmd_o.shift = 1'b1;
        end else if (stat_i.out_free) begin
          cmd_o.emit  = 1'b1;
          cmd_o.shift = 1'b1;
        end
      end
      default: state_d = gr48_pkg::ST_IDLE;
    endcase
  end

endmodule

@@ rtl/gr48_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gr48_dp
// Datapath: font store, glyph shift register, cursor and pixel output word.
// ----------------------------------------------------------------------------
module gr48_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         cmd_i,
  input  logic [7:0]         char_code_i,
  input  logic [8:0]         font_addr_i,
  input  logic [7:0]         font_byte_i,
  input  logic [8:0]         new_cursor_x_i,
  input  logic [7:0]         new_cursor_y_i,
  input  logic [7:0]         text_color_i,
  input  logic [3:0]         line_step_i,
  input  gr48_pkg::dp_cmd_t  cmd_in_i,
  output gr48_pkg::dp_stat_t stat_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [8:0]         pixel_x_o,
  output logic [7:0]         pixel_y_o,
  output logic [7:0]         pixel_color_o,
  output logic               last_o
);

  logic [7:0] font_mem [gr48_pkg::FONT_DEPTH];
  logic [7:0] rdata_q;
  logic       rd_vld_q;
  logic [7:0] code_q;
  logic [7:0] glyph;
  logic [2:0] fcnt_q;
  logic [8:0] raddr;
  logic       mem_we;
  logic [3:0] nib;
  logic [gr48_pkg::GLYPH_BITS-1:0] sr_q;
  logic [4:0] pos_q;
  logic [8:0] col_q;
  logic [7:0] row_q;
  logic [9:0] next_col;
  logic [8:0] next_row;
  logic       wrap;
  logic       out_valid_q;
  logic [8:0] pixel_x_q;
  logic [7:0] pixel_y_q;
  logic [7:0] pixel_color_q;
  logic       last_q;
  gr48_pkg::cmd_e cmd;

  assign cmd   = gr48_pkg::cmd_e'(cmd_i);
  assign glyph = code_q - gr48_pkg::CODE_FIRST;
  assign raddr = {glyph[6:1], fcnt_q};
  assign nib   = glyph[0] ? rdata_q[3:0] : rdata_q[7:4];
  assign mem_we = cmd_in_i.load_font &&
                  ({1'b0, font_addr_i} < 10'(gr48_pkg::FONT_DEPTH));

  always_comb begin
    stat_o          = '0;
    unique case (cmd)
      gr48_pkg::CMD_DRAW: stat_o.is_draw = (char_code_i >= gr48_pkg::CODE_FIRST) &&
                                           (char_code_i <= gr48_pkg::CODE_LAST);
      gr48_pkg::CMD_LOAD:       stat_o.is_load = 1'b1;
      gr48_pkg::CMD_SET_CURSOR: stat_o.is_set  = 1'b1;
      default: ;
    endcase
    stat_o.fetch_done  = (fcnt_q == 3'd7);
    stat_o.glyph_empty = (sr_q == '0);
    stat_o.bit_set     = sr_q[gr48_pkg::GLYPH_BITS-1];
    stat_o.out_free    = !out_valid_q || out_ready_i;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      font_mem[font_addr_i] <= font_byte_i;
    end
    rdata_q <= font_mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_in_i.fetch;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_in_i.start_draw) begin
      code_q <= char_code_i;
      fcnt_q <= 3'd0;
      pos_q  <= 5'd0;
    end else begin
      if (cmd_in_i.fetch) begin
        fcnt_q <= fcnt_q + 3'd1;
      end
      if (cmd_in_i.shift) begin
        pos_q <= pos_q + 5'd1;
      end
    end
    if (rd_vld_q) begin
      sr_q <= {sr_q[gr48_pkg::GLYPH_BITS-5:0], nib};
    end else if (cmd_in_i.shift) begin
      sr_q <= {sr_q[gr48_pkg::GLYPH_BITS-2:0], 1'b0};
    end
  end

  assign next_col = {1'b0, col_q} + 10'(gr48_pkg::GLYPH_W);
  assign wrap     = (next_col >= 10'(gr48_pkg::SCREEN_WIDTH)) ||
                    (next_col > 10'(gr48_pkg::COL_LIMIT));

  always_comb begin
    next_row = {1'b0, row_q} + {5'd0, line_step_i};
    if ({1'b0, next_row} >= 10'(gr48_pkg::BOTTOM_LIMIT)) begin
      next_row = 9'(gr48_pkg::BOTTOM_LIMIT - gr48_pkg::GLYPH_H);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= 9'd0;
      row_q <= 8'd0;
    end else if (cmd_in_i.set_cursor) begin
      col_q <= new_cursor_x_i;
      row_q <= new_cursor_y_i;
    end else if (cmd_in_i.advance) begin
      if (wrap) begin
        col_q <= 9'd0;
        row_q <= next_row[7:0];
      end else begin
        col_q <= next_col[8:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_in_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_in_i.emit) begin
      pixel_x_q     <= col_q + {7'd0, pos_q[1:0]};
      pixel_y_q     <= row_q + {5'd0, pos_q[4:2]};
      pixel_color_q <= text_color_i;
      last_q        <= (sr_q[gr48_pkg::GLYPH_BITS-2:0] == '0);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = pixel_x_q;
  assign pixel_y_o     = pixel_y_q;
  assign pixel_color_o = pixel_color_q;
  assign last_o        = last_q;

endmodule

@@ rtl/glyph_rasterizer_4x8.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_rasterizer_4x8
// Draws 4x8 text glyphs from a packed font store as a stream of pixel words.
// ----------------------------------------------------------------------------
// Load and set-cursor words complete on acceptance; out-of-range draw codes are
// accepted and dropped. A draw word is accepted, reads the glyph rows from the
// font store (one row per read port access), passes a drain state, then steps
// through the glyph bits up to the last set bit, one glyph bit per cycle while
// the sink is ready, with a pixel word for each set bit; a pending pixel word
// the sink holds off stalls the stepping. Reset clears the cursor, sets
// text_color to 15 and line_step to 8; the font store holds no reset value.
module glyph_rasterizer_4x8 (
  input  logic        clk_i,
  input  logic        rst_ni,
  gr48_in_if.sink     in_i,
  gr48_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] text_color;
  logic [3:0] line_step;
  logic       in_ready;
  logic       out_valid;
  logic [8:0] pixel_x;
  logic [7:0] pixel_y;
  logic [7:0] pixel_color;
  logic       last;
  gr48_pkg::dp_cmd_t  dp_cmd;
  gr48_pkg::dp_stat_t dp_stat;

  gr48_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .text_color_o (text_color),
    .line_step_o  (line_step)
  );

  gr48_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  gr48_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (in_i.cmd),
    .char_code_i    (in_i.char_code),
    .font_addr_i    (in_i.font_addr),
    .font_byte_i    (in_i.font_byte),
    .new_cursor_x_i (in_i.new_cursor_x),
    .new_cursor_y_i (in_i.new_cursor_y),
    .text_color_i   (text_color),
    .line_step_i    (line_step),
    .cmd_in_i       (dp_cmd),
    .stat_o         (dp_stat),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_o.ready),
    .pixel_x_o      (pixel_x),
    .pixel_y_o      (pixel_y),
    .pixel_color_o  (pixel_color),
    .last_o         (last)
  );

  assign in_i.ready        = in_ready;
  assign out_o.valid       = out_valid;
  assign out_o.pixel_x     = pixel_x;
  assign out_o.pixel_y     = pixel_y;
  assign out_o.pixel_color = pixel_color;
  assign out_o.last        = last;

endmodule
